// ===== hw/rtl/quadratic_regression_evaluator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the regression evaluator.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_REGRESSION_EVALUATOR_TOP_MACROS_SVH
`define QUADRATIC_REGRESSION_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define QRE_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define QRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qre_pkg.sv =====
// ----------------------------------------------------------------------------
// qre_pkg
// Sizes, codes and shared types of the quadratic regression evaluator.
// ----------------------------------------------------------------------------
package qre_pkg;

    localparam int MAX_FEATURES = 16;
    localparam int COEFF_DEPTH  = 256;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int CIDX_W    = 8;
    localparam int CFG_W     = 5;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int SCORE_W   = 40;

    // Datapath widths
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int MAC_W  = 3 * SAMPLE_W;
    localparam int ACC_W  = 56;
    localparam int RND_SH = 16;
    localparam int SAT_W  = ACC_W + 1 - RND_SH;

    // Derived sizes
    localparam int N_W       = $clog2(MAX_FEATURES + 1);
    localparam int K_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int MAX_TERMS = 2 * MAX_FEATURES + MAX_FEATURES * (MAX_FEATURES - 1) / 2 + 1;
    localparam int TERM_W    = $clog2(MAX_TERMS);
    localparam int CADDR_W   = $clog2(COEFF_DEPTH);
    localparam int CMP_A     = (TERM_W > CIDX_W) ? TERM_W : CIDX_W;
    localparam int CMP_W     = ((CMP_A > CADDR_W) ? CMP_A : CADDR_W) + 1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Scale factor for linear and bias terms (1.0 in Q8.8)
    localparam logic signed [SAMPLE_W-1:0] LIN_SCALE = 16'sd256;

    localparam logic [CFG_W-1:0] NCOUNT_RESET = CFG_W'(MAX_FEATURES);

    typedef enum logic [0:0] {
        OP_COEFF   = 1'b0,
        OP_FEATURE = 1'b1
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUAD   = 2'd0,
        MODE_LIN    = 2'd1,
        MODE_NOBIAS = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 1'b0,
        CFG_NCOUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TERMS,
        S_DRAIN,
        S_OUT
    } t_bstate;

    typedef enum logic [1:0] {
        T_SQ,
        T_PAIR,
        T_LIN,
        T_BIAS
    } t_term;

    // Decoded configuration seen by front and back
    typedef struct packed {
        logic           quad;
        logic           bias;
        logic [N_W-1:0] n;
    } t_cfg;

    // One classified beat in the queue
    typedef struct packed {
        t_op                 op;
        logic                last;
        logic [K_W-1:0]      k;
        logic [CIDX_W-1:0]   idx;
        logic [SAMPLE_W-1:0] value;
    } t_item;

endpackage

// ===== hw/rtl/quadratic_regression_evaluator_top.sv =====
// Terms: per feature the back end issues a square, one pair per earlier position and a
//   linear term in quadratic mode, only the linear term in linear mode; a last feature adds any bias.
// Throughput: the back end takes one term per cycle through one shared MAC pipeline;
//   it takes a new beat from the queue only while idle, once the terms of the last one are issued,
//   and after a vector's last feature it drains the pipeline and waits for the result register to be free.
// Reset: synchronous, active low; clears control, the sum and the configuration.
// ----------------------------------------------------------------------------
// quadratic_regression_evaluator_top
// Degree-two regression scorer: queue-style input and result ports, a plain
// configuration write port, front classifier, beat queue and MAC back end.
// ----------------------------------------------------------------------------
module quadratic_regression_evaluator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_coeff_index,
    input  logic [15:0] i_coeff_value,
    input  logic [15:0] i_feature,
    output logic        empty,
    input  logic        pop,
    output logic [39:0] o_score,
    output logic        o_saturated
);
    import qre_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [CFG_W-1:0]  r_ncount;
    logic [N_W-1:0]    w_n;
    t_cfg              w_cfg;
    logic              w_q_full;
    logic              w_q_push;
    t_item             w_q_item;
    t_item             w_q_head;
    logic              w_q_empty;
    logic              w_q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_QUAD;
            r_ncount <= NCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_NCOUNT: r_ncount <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Clamp the vector length; unused mode code behaves as no-bias
    always_comb begin
        if (r_ncount == '0) begin
            w_n = N_W'(1);
        end else if (32'(r_ncount) > 32'(MAX_FEATURES)) begin
            w_n = N_W'(MAX_FEATURES);
        end else begin
            w_n = N_W'(r_ncount);
        end
        w_cfg.quad = (r_mode == MODE_QUAD);
        w_cfg.bias = (r_mode == MODE_QUAD) || (r_mode == MODE_LIN);
        w_cfg.n    = w_n;
    end

    qre_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_clr         (i_cfg_we),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_feature     (i_feature),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_q_item)
    );

    qre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty)
    );

    qre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_clr       (i_cfg_we),
        .i_head      (w_q_head),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_score     (o_score),
        .o_saturated (o_saturated)
    );

endmodule

// ===== hw/rtl/qre_front.sv =====
// ----------------------------------------------------------------------------
// qre_front
// Accepts input beats, tracks the feature position within the vector and
// pushes classified beats into the queue.
// ----------------------------------------------------------------------------
module qre_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qre_pkg::t_cfg i_cfg,
    input  logic          i_clr,
    input  logic          push,
    output logic          full,
    input  logic          i_op,
    input  logic [7:0]    i_coeff_index,
    input  logic [15:0]   i_coeff_value,
    input  logic [15:0]   i_feature,
    input  logic          i_q_full,
    output logic          o_q_push,
    output qre_pkg::t_item o_q_item
);
    import qre_pkg::*;

    logic [K_W-1:0] r_count;
    logic [K_W-1:0] n_count;
    logic [K_W-1:0] w_k;
    logic           w_last;
    logic           w_accept;
    t_op            w_op;

    // Wrap the position when it has run past the vector length
    assign w_k      = (N_W'(r_count) >= i_cfg.n) ? '0 : r_count;
    assign w_last   = (N_W'(w_k) + N_W'(1)) >= i_cfg.n;
    assign w_op     = t_op'(i_op);
    assign w_accept = push && !i_q_full;
    assign full     = i_q_full;

    // Build the queue beat
    always_comb begin
        o_q_push       = w_accept;
        o_q_item.op    = w_op;
        o_q_item.last  = w_last;
        o_q_item.k     = w_k;
        o_q_item.idx   = i_coeff_index;
        o_q_item.value = (w_op == OP_FEATURE) ? i_feature : i_coeff_value;
    end

    // Advance the feature position
    always_comb begin
        n_count = r_count;
        if (i_clr) begin
            n_count = '0;
        end else if (w_accept && w_op == OP_FEATURE) begin
            n_count = w_last ? '0 : w_k + K_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/qre_queue.sv =====
// ----------------------------------------------------------------------------
// qre_queue
// Short first-in first-out queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module qre_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qre_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output qre_pkg::t_item o_head,
    output logic           o_empty
);
    import qre_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Hold the entries
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/qre_back.sv =====
// ----------------------------------------------------------------------------
// qre_back
// Executes queued beats: coefficient writes, and for each feature a
// sequence of multiply-accumulate terms through a two-multiplier pipeline,
// then rounding, saturation and the result register.
// ----------------------------------------------------------------------------
`include "quadratic_regression_evaluator_top_macros.svh"

module qre_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qre_pkg::t_cfg  i_cfg,
    input  logic           i_clr,
    input  qre_pkg::t_item i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [39:0]    o_score,
    output logic           o_saturated
);
    import qre_pkg::*;

    // Sequencer state
    t_bstate            r_state;
    t_bstate            n_state;
    t_term              r_kind;
    t_term              n_kind;
    logic [K_W-1:0]     r_i;
    logic [K_W-1:0]     n_i;
    logic [TERM_W-1:0]  r_pidx;
    logic [TERM_W-1:0]  n_pidx;

    // Current feature
    logic signed [SAMPLE_W-1:0] r_f;
    logic [K_W-1:0]             r_k;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_store [MAX_FEATURES];

    // Coefficient memory
    logic [SAMPLE_W-1:0] r_cmem [COEFF_DEPTH];

    // Term issue
    logic                       w_issue;
    logic signed [SAMPLE_W-1:0] w_a;
    logic signed [SAMPLE_W-1:0] w_b;
    logic [TERM_W-1:0]          w_idx;
    logic [CMP_W-1:0]           w_raddr;
    logic [CMP_W-1:0]           w_waddr;
    logic                       w_cmem_we;
    logic [2*N_W-1:0]           w_nn;
    logic [TERM_W-1:0]          w_lin_base;
    logic [TERM_W-1:0]          w_pstep;
    logic                       w_take;

    // Pipeline
    logic                       r_v1;
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_p;
    logic [SAMPLE_W-1:0]        r_c;
    logic                       r_cz;
    logic signed [SAMPLE_W-1:0] w_cop;
    logic signed [MAC_W-1:0]    w_m;
    logic signed [MAC_W-1:0]    r_m;
    logic signed [ACC_W-1:0]    r_acc;

    // Result
    logic signed [ACC_W:0]      w_t;
    logic signed [SAT_W-1:0]    w_s;
    logic                       w_sat;
    logic [SCORE_W-1:0]         w_score;
    logic                       w_out_free;
    logic                       w_out_load;
    logic                       r_out_valid;
    logic [SCORE_W-1:0]         r_score;
    logic                       r_sat;

    // Index of the first linear term: N squares then N(N-1)/2 pairs
    assign w_nn       = (2*N_W)'(i_cfg.n) * (2*N_W)'(i_cfg.n - N_W'(1));
    assign w_lin_base = TERM_W'(i_cfg.n) + TERM_W'(w_nn >> 1);
    // Step between consecutive pair indices down a column
    assign w_pstep    = TERM_W'(i_cfg.n) - TERM_W'(2) - TERM_W'(r_i);

    // Select operands and coefficient index of the term being issued
    always_comb begin
        w_issue = (r_state == S_TERMS);
        w_a     = LIN_SCALE;
        w_b     = LIN_SCALE;
        w_idx   = '0;
        case (r_kind)
            T_SQ: begin
                w_a   = r_f;
                w_b   = r_f;
                w_idx = TERM_W'(r_k);
            end
            T_PAIR: begin
                w_a   = r_store[r_i];
                w_b   = r_f;
                w_idx = r_pidx;
            end
            T_LIN: begin
                w_b   = r_f;
                w_idx = i_cfg.quad ? w_lin_base + TERM_W'(r_k) : TERM_W'(r_k);
            end
            T_BIAS: begin
                w_idx = i_cfg.quad ? w_lin_base + TERM_W'(i_cfg.n) : TERM_W'(i_cfg.n);
            end
            default: begin
                w_idx = '0;
            end
        endcase
    end

    assign w_raddr    = CMP_W'(w_idx);
    assign w_waddr    = CMP_W'(i_head.idx);
    assign w_take     = (r_state == S_IDLE) && !i_q_empty;
    assign w_cmem_we  = w_take && (i_head.op == OP_COEFF) &&
                        (w_waddr < CMP_W'(COEFF_DEPTH));
    assign o_q_pop    = w_take;
    assign w_out_free = !r_out_valid || pop;

    // Next state and term sequencing
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_i        = r_i;
        n_pidx     = r_pidx;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_take && i_head.op == OP_FEATURE) begin
                    n_state = S_TERMS;
                    n_kind  = i_cfg.quad ? T_SQ : T_LIN;
                    n_i     = '0;
                    n_pidx  = TERM_W'(i_cfg.n) + TERM_W'(i_head.k) - TERM_W'(1);
                end
            end
            S_TERMS: begin
                case (r_kind)
                    T_SQ: begin
                        n_kind = (r_k != '0) ? T_PAIR : T_LIN;
                    end
                    T_PAIR: begin
                        n_i    = r_i + K_W'(1);
                        n_pidx = r_pidx + w_pstep;
                        if (r_i + K_W'(1) == r_k) begin
                            n_kind = T_LIN;
                        end
                    end
                    T_LIN: begin
                        if (r_last && i_cfg.bias) begin
                            n_kind = T_BIAS;
                        end else begin
                            n_state = r_last ? S_DRAIN : S_IDLE;
                        end
                    end
                    T_BIAS: begin
                        n_state = S_DRAIN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= T_SQ;
            r_i     <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_i     <= n_i;
            r_pidx  <= n_pidx;
        end
    end

    // Latch the feature and store it for later pairs
    always_ff @(posedge i_clk) begin
        if (w_take && i_head.op == OP_FEATURE) begin
            r_f               <= $signed(i_head.value);
            r_k               <= i_head.k;
            r_last            <= i_head.last;
            r_store[i_head.k] <= $signed(i_head.value);
        end
    end

    // Write and read the coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_cmem_we) begin
            r_cmem[w_waddr[CADDR_W-1:0]] <= i_head.value;
        end
        if (w_issue) begin
            r_c <= r_cmem[w_raddr[CADDR_W-1:0]];
        end
    end

    // Stage one: operand product; stage two: times coefficient
    assign w_cop = r_cz ? '0 : $signed(r_c);
    assign w_m   = MAC_W'(r_p) * MAC_W'(w_cop);

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_p  <= PROD_W'(w_a) * PROD_W'(w_b);
            r_cz <= !(w_raddr < CMP_W'(COEFF_DEPTH));
        end
        if (r_v1) begin
            r_m <= w_m;
        end
    end

    // Accumulate; drop the sum on a register write or after the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (i_clr || w_out_load) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_m);
            end
        end
    end

    // Round half up to Q32.8 and clip to the score range
    assign w_t     = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(1 << (RND_SH - 1));
    assign w_s     = w_t[ACC_W:RND_SH];
    assign w_sat   = w_s[SAT_W-1] != w_s[SCORE_W-1];
    assign w_score = !w_sat ? w_s[SCORE_W-1:0] :
                     (w_s[SAT_W-1] ? {1'b1, {(SCORE_W-1){1'b0}}} :
                                     {1'b0, {(SCORE_W-1){1'b1}}});

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_score <= w_score;
            r_sat   <= w_sat;
        end
    end

    assign empty       = !r_out_valid;
    assign o_score     = r_score;
    assign o_saturated = r_sat;

    `QRE_ASSERT(a_drain_done, i_clk, i_rst_n, r_state == S_OUT, !r_v1 && !r_v2, "result taken before pipeline drained")
    `QRE_ASSERT(a_no_rw_clash, i_clk, i_rst_n, w_cmem_we, !w_issue, "coefficient write during term issue")
    `QRE_ASSERT(a_pair_bound, i_clk, i_rst_n, r_state == S_TERMS && r_kind == T_PAIR, r_i < r_k, "pair row past current feature")
    `QRE_ASSERT_NEXT(a_acc_cleared, i_clk, i_rst_n, w_out_load, r_acc == '0 && r_out_valid, "sum not cleared after result")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the regression evaluator: fills the coefficient
// memory, walks a short table of hand-picked beats, then runs random phases
// under changing mode and vector length. Every score is checked against an
// in-bench fixed point scorer or the table; both queue ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import qre_pkg::*;

    localparam int      DRAIN_CYCLES = 160;
    localparam int      RANDOM_BEATS = 1000;
    localparam int      LIMIT_CYCLES = 1_000_000;
    localparam longint  SCORE_MAX    = 64'sd549755813887;
    localparam longint  SCORE_MIN    = -64'sd549755813888;
    // Unused mode code; behaves like linear without bias
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic        sat;
        logic [39:0] score;
    } t_score_exp;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_COEFF,
        ROW_FEAT
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_reg    reg_sel;
        logic [4:0]  cfg_val;
        logic [7:0]  idx;
        logic [15:0] value;
        logic [15:0] sample;
        bit          typed_exp;
        longint      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [4:0]  i_cfg_data;
    logic        push;
    logic        full;
    logic        i_op;
    logic [7:0]  i_coeff_index;
    logic [15:0] i_coeff_value;
    logic [15:0] i_feature;
    logic        empty;
    logic        pop;
    logic [39:0] o_score;
    logic        o_saturated;

    // Scorer state, mirrored from the block
    logic signed [15:0] coef_mem [COEFF_DEPTH];
    logic signed [15:0] sample_store [MAX_FEATURES];
    int                 samples_seen;
    longint             partial_sum;
    logic [1:0]         mode_q;
    logic [4:0]         ncount_q;

    t_score_exp pending_scores[$];
    t_row       plan[$];

    int beats_sent  = 0;
    int rand_beats  = 0;
    int reg_writes  = 0;
    int scores_seen = 0;
    int mismatches  = 0;
    int tx_left     = 0;
    int rx_left     = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;

    quadratic_regression_evaluator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_feature     (i_feature),
        .empty         (empty),
        .pop           (pop),
        .o_score       (o_score),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs
    initial begin
        #(LIMIT_CYCLES * 4);
        $display("FAILURE");
        $finish;
    end

    // Wait length for one beat; alternate busy stretches with quiet ones
    function automatic int draw_wait(inout int left, inout bit quiet);
        if (left == 0) begin
            left  = $urandom_range(8, 60);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic longint coef_at(int addr);
        if (addr >= COEFF_DEPTH)
            return 0;
        return longint'(coef_mem[addr]);
    endfunction

    function automatic int vec_len();
        if (ncount_q == 0)
            return 1;
        if (ncount_q > MAX_FEATURES)
            return MAX_FEATURES;
        return int'(ncount_q);
    endfunction

    // Fold one accepted beat into the scorer; flag a finished vector
    task automatic fold_beat(input t_op op, input logic [7:0] addr, input logic [15:0] val,
                             input logic [15:0] x, output bit done, output t_score_exp res);
        int     n;
        int     k;
        int     i;
        int     slot;
        longint f;
        longint r;
        done = 1'b0;
        res  = '0;
        if (op == OP_COEFF) begin
            if (addr < COEFF_DEPTH)
                coef_mem[addr] = val;
        end else begin
            n = vec_len();
            k = samples_seen;
            if (k >= n)
                k = 0;
            f = $signed(x);
            sample_store[k] = x;
            if (mode_q == MODE_QUAD) begin
                partial_sum += f * f * coef_at(k);
                // cross terms with every earlier sample of this vector
                for (i = 0; i < k; i++) begin
                    slot = n + i * (n - 1) - i * (i - 1) / 2 + (k - i - 1);
                    partial_sum += longint'(sample_store[i]) * f * coef_at(slot);
                end
                partial_sum += f * coef_at(n + n * (n - 1) / 2 + k) * 256;
            end else begin
                partial_sum += f * coef_at(k) * 256;
            end
            if (k + 1 < n) begin
                samples_seen = k + 1;
            end else begin
                if (mode_q == MODE_QUAD)
                    partial_sum += coef_at(2 * n + n * (n - 1) / 2) * 65536;
                else if (mode_q == MODE_LIN)
                    partial_sum += coef_at(n) * 65536;
                // round half up to Q32.8, then clip
                r = (partial_sum + 32768) >>> 16;
                if (r > SCORE_MAX) begin
                    r       = SCORE_MAX;
                    res.sat = 1'b1;
                end else if (r < SCORE_MIN) begin
                    r       = SCORE_MIN;
                    res.sat = 1'b1;
                end
                res.score    = r[39:0];
                done         = 1'b1;
                samples_seen = 0;
                partial_sum  = 0;
            end
        end
    endtask

    // Offer one beat on the input queue and fold it in once taken
    task automatic send_beat(input t_op op, input logic [7:0] addr, input logic [15:0] val,
                             input logic [15:0] x, input bit typed, input longint want);
        int         gap;
        bit         done;
        t_score_exp res;
        gap = draw_wait(tx_left, tx_quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_coeff_index <= addr;
        i_coeff_value <= val;
        i_feature     <= x;
        do @(negedge i_clk); while (full !== 1'b0);
        @(posedge i_clk);
        beats_sent++;
        fold_beat(op, addr, val, x, done, res);
        if (done) begin
            if (typed) begin
                res.score = want[39:0];
                res.sat   = 1'b0;
            end
            pending_scores.push_back(res);
        end
    endtask

    // Drop push, let every pending score come out, then let the back end drain
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [4:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_MODE)
            mode_q = d[1:0];
        else
            ncount_q = d;
        // any register write abandons the vector in progress
        samples_seen = 0;
        partial_sum  = 0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic void plan_cfg(t_cfg_reg sel, logic [4:0] d);
        t_row r;
        r = '{kind: ROW_CFG, reg_sel: sel, cfg_val: d, default: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_coeff(logic [7:0] addr, logic [15:0] val);
        t_row r;
        r = '{kind: ROW_COEFF, reg_sel: CFG_MODE, idx: addr, value: val, default: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_feat(logic [15:0] x, bit typed, longint want);
        t_row r;
        r = '{kind: ROW_FEAT, reg_sel: CFG_MODE, sample: x, typed_exp: typed, want: want,
              default: '0};
        plan.push_back(r);
    endfunction

    // Result side: stall at random, check each score beat against the oldest pending one
    initial begin
        t_score_exp want;
        int         gap;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_wait(rx_left, rx_quiet);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(negedge i_clk); while (empty !== 1'b0);
            if (pending_scores.size() == 0) begin
                $error("score %0d arrived with no score pending", $signed(o_score));
                mismatches++;
            end else begin
                want = pending_scores.pop_front();
                if (o_score !== want.score) begin
                    $error("score: expected %0d, actual %0d",
                           $signed(want.score), $signed(o_score));
                    mismatches++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0d, actual %0d", want.sat, o_saturated);
                    mismatches++;
                end
            end
            scores_seen++;
            @(posedge i_clk);
        end
    end

    initial begin
        int          n;
        int          terms;
        int          budget;
        logic [7:0]  addr;
        logic [4:0]  mode_val;
        logic [4:0]  count_val;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MODE;
        i_cfg_data    <= '0;
        push          <= 1'b0;
        i_op          <= OP_COEFF;
        i_coeff_index <= '0;
        i_coeff_value <= '0;
        i_feature     <= '0;
        mode_q       = MODE_QUAD;
        ncount_q     = 5'(MAX_FEATURES);
        samples_seen = 0;
        partial_sum  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole coefficient memory so no read ever hits an unwritten entry
        for (int a = 0; a < COEFF_DEPTH; a++)
            send_beat(OP_COEFF, 8'(a), draw_sample(), 16'($urandom), 1'b0, 0);

        // Directed table: identity weight, rounding halves, bias, odd registers
        plan_cfg(CFG_MODE, 5'(MODE_LIN));
        plan_cfg(CFG_NCOUNT, 5'd1);
        plan_coeff(8'd0, 16'h0100);
        plan_coeff(8'd1, 16'h0000);
        plan_feat(16'h7FFF, 1'b1, 32767);
        plan_feat(16'h8000, 1'b1, -32768);
        plan_feat(16'h0000, 1'b1, 0);
        plan_coeff(8'd0, 16'h0080);
        plan_feat(16'h0001, 1'b1, 1);
        plan_feat(16'hFFFF, 1'b1, 0);
        plan_coeff(8'd1, 16'h0100);
        plan_feat(16'h0000, 1'b1, 256);
        plan_cfg(CFG_MODE, {3'b101, MODE_SPARE});
        plan_feat(16'h0000, 1'b1, 0);
        plan_feat(16'h7FFF, 1'b1, 16384);
        plan_cfg(CFG_NCOUNT, 5'd0);
        plan_coeff(8'd0, 16'h8000);
        plan_feat(16'h0100, 1'b1, -32768);
        // quadratic, two features: squares, cross term, linear, bias
        plan_cfg(CFG_MODE, 5'(MODE_QUAD));
        plan_cfg(CFG_NCOUNT, 5'd2);
        plan_coeff(8'd2, 16'h7FFF);
        plan_feat(16'h8000, 1'b0, 0);
        plan_feat(16'h8000, 1'b0, 0);
        plan_feat(16'h7FFF, 1'b0, 0);
        plan_coeff(8'd3, 16'h8000);
        plan_feat(16'h7FFF, 1'b0, 0);
        plan_feat(16'h1234, 1'b0, 0);
        plan_cfg(CFG_NCOUNT, 5'd2);
        plan_feat(16'h0100, 1'b0, 0);
        plan_feat(16'hFF00, 1'b0, 0);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(plan[i].reg_sel, plan[i].cfg_val);
                end
                ROW_COEFF: begin
                    send_beat(OP_COEFF, plan[i].idx, plan[i].value, 16'($urandom), 1'b0, 0);
                end
                default: begin
                    send_beat(OP_FEATURE, 8'($urandom), 16'($urandom), plan[i].sample,
                              plan[i].typed_exp, plan[i].want);
                end
            endcase
        end

        // Random phases: new register settings, then vectors with stray writes
        while (rand_beats < RANDOM_BEATS) begin
            wait_idle();
            mode_val = {3'($urandom), 2'($urandom_range(0, 3))};
            case ($urandom_range(0, 9))
                0:       count_val = 5'd0;
                1:       count_val = 5'($urandom_range(17, 31));
                2:       count_val = 5'(MAX_FEATURES);
                3, 4:    count_val = 5'($urandom_range(5, 15));
                default: count_val = 5'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_MODE, mode_val);
                write_reg(CFG_NCOUNT, count_val);
            end else begin
                write_reg(CFG_NCOUNT, count_val);
                write_reg(CFG_MODE, mode_val);
            end
            n      = vec_len();
            terms  = (mode_q == MODE_QUAD) ? 2 * n + n * (n - 1) / 2 + 1 : n + 1;
            budget = n * $urandom_range(1, (n <= 4) ? 8 : 3);
            // sometimes stop mid-vector so the next register write abandons it
            if ($urandom_range(0, 3) == 0)
                budget += $urandom_range(1, n);
            repeat (budget) begin
                if ($urandom_range(0, 99) < 8) begin
                    addr = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, terms - 1));
                    send_beat(OP_COEFF, addr, draw_sample(), 16'($urandom), 1'b0, 0);
                end else begin
                    send_beat(OP_FEATURE, 8'($urandom), 16'($urandom), draw_sample(),
                              1'b0, 0);
                end
                rand_beats++;
            end
        end

        wait_idle();
        $display("Covered %0d input beats (%0d random) over %0d register writes,",
                 beats_sent, rand_beats, reg_writes);
        $display("all three modes plus the spare code; %0d scores compared.", scores_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qre_pkg.sv
hw/rtl/qre_front.sv
hw/rtl/qre_queue.sv
hw/rtl/qre_back.sv
hw/rtl/quadratic_regression_evaluator_top.sv
verif/tb_top.sv
